// ===== rtl/core/iterative_sigma_clip_unit_assert.svh =====
// Assertion macros for the sigma clipping unit.
// Used by modules that sample clk and rst_n in their own scope.
`ifndef ITERATIVE_SIGMA_CLIP_UNIT_ASSERT_SVH
`define ITERATIVE_SIGMA_CLIP_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define ISC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sigma clip assertion failed");
`define ISC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sigma clip assertion failed");
`else
`define ISC_ASSERT_IMP(lbl, ante, cons)
`define ISC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/isc_pkg.sv =====
// Shared constants, state type and controller/datapath interface structs
// for the sigma clipping unit. No dependencies.
package isc_pkg;

  localparam int MAX_SAMPLES = 64;
  localparam int IDX_W       = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int OUT_IDX_W   = 6;
  localparam int SAMPLE_W    = 24;
  localparam int CM_W        = 8;
  localparam logic [CM_W-1:0] CM_RESET = 8'd80;
  localparam int SUM_W       = SAMPLE_W + IDX_W;
  localparam int SQ_W        = 2 * SAMPLE_W - 1;
  localparam int QS_W        = SQ_W + IDX_W;
  localparam int D_W         = CNT_W + QS_W;
  localparam int VAR_FRAC    = 16;
  localparam int MEAN_FRAC   = 8;
  localparam int DIVD_W      = D_W + VAR_FRAC;
  localparam int DEN_W       = 18;
  localparam int MQ_W        = SUM_W + MEAN_FRAC;
  localparam int V_W         = 64;
  localparam int ROOT_W      = 32;
  localparam int MEAN_W      = 32;
  localparam int SIGMA_W     = 31;
  localparam int DIFF_W      = MEAN_W + 2;
  localparam int DIST_W      = DIFF_W - 1;
  localparam int THR_W       = CM_W + ROOT_W;
  localparam int PASS_W      = 7;

  typedef enum logic [4:0] {
    S_LOAD, S_ST_CLR, S_ST_RD, S_ST_SQ, S_ST_ACC,
    S_MEAN_GO, S_MEAN_WAIT, S_VAR_A, S_VAR_B, S_VAR_GO, S_VAR_WAIT, S_SQRT_WAIT,
    S_CL_CLR, S_CL_RD, S_CL_MUL, S_CL_CMP,
    S_EM_CLR, S_EM_RD, S_EM_OUT, S_END
  } isc_state_t;

  typedef struct packed {
    logic load;
    logic st_clr;
    logic rd;
    logic sq;
    logic acc;
    logic mean_go;
    logic mean_fin;
    logic var_a;
    logic var_b;
    logic var_go;
    logic var_fin;
    logic sqrt_fin;
    logic cl_clr;
    logic cl_mul;
    logic cl_cmp;
    logic em_clr;
    logic em_load;
    logic end_clr;
  } isc_cmd_t;

  typedef struct packed {
    logic idx_end;
    logic n_zero;
    logic n_lt2;
    logic dropped;
    logic div_busy;
    logic div_done;
    logic sqrt_busy;
    logic sqrt_done;
    logic out_free;
    logic cnt_zero;
  } isc_status_t;

endpackage

// ===== rtl/core/isc_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on isc_pkg for operand widths.
module isc_div import isc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DEN_W-1:0]  divisor,
  output logic              busy,
  output logic              done,
  output logic [DIVD_W-1:0] quot,
  output logic [DEN_W-1:0]  rem
);

  localparam int DC_W = $clog2(DIVD_W);

  logic              busy_r, done_r;
  logic [DC_W-1:0]   cnt_r;
  logic [DIVD_W-1:0] dq_r;
  logic [DEN_W-1:0]  rem_r, dsr_r;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    shifted;

  assign shifted = {rem_r, dq_r[DIVD_W-1]};
  assign trial   = shifted - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DC_W'(DIVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      if (!trial[DEN_W]) begin
        rem_r <= trial[DEN_W-1:0];
        dq_r  <= {dq_r[DIVD_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[DEN_W-1:0];
        dq_r  <= {dq_r[DIVD_W-2:0], 1'b0};
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = dq_r;
  assign rem  = rem_r;

endmodule

// ===== rtl/core/isc_sqrt.sv =====
// Integer square root, two radicand bits per cycle.
// Depends on isc_pkg for widths.
module isc_sqrt import isc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [V_W-1:0]    radicand,
  output logic              busy,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int SC_W = $clog2(V_W / 2);

  logic            busy_r, done_r;
  logic [SC_W-1:0] cnt_r;
  logic [V_W-1:0]  v_r, res_r, bit_r, trial;

  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == SC_W'(V_W / 2 - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= radicand;
      res_r <= '0;
      bit_r <= {2'b01, {(V_W-2){1'b0}}};
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_r   <= v_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign root = res_r[ROOT_W-1:0];

endmodule

// ===== rtl/core/isc_datapath.sv =====
// Datapath: sample store, keep mask, accumulators, statistics arithmetic,
// clip compare and output register. Depends on isc_pkg, isc_div, isc_sqrt.
module isc_datapath import isc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  isc_cmd_t                   cmd,
  output isc_status_t                st,
  input  logic                       cfg_wr_en,
  input  logic [CM_W-1:0]            cfg_wr_data,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_present,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [OUT_IDX_W-1:0]       out_index,
  output logic signed [SAMPLE_W-1:0] out_value,
  output logic                       out_kept,
  output logic signed [MEAN_W-1:0]   out_final_mean,
  output logic [SIGMA_W-1:0]         out_final_sigma,
  output logic [PASS_W-1:0]          out_passes,
  output logic [CNT_W-1:0]           out_kept_count,
  output logic                       out_stats_valid,
  output logic                       out_overflowed,
  output logic                       out_last_result
);

  logic signed [SAMPLE_W-1:0] mem [MAX_SAMPLES];

  logic [CM_W-1:0]            cm_r;
  logic [CNT_W-1:0]           load_cnt_r, idx_r, n_r;
  logic [MAX_SAMPLES-1:0]     keep_r;
  logic                       ovf_r, dropped_r, out_valid_r;
  logic [PASS_W-1:0]          passes_r;

  logic signed [SAMPLE_W-1:0] rd_data_r;
  logic [SQ_W-1:0]            sq_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic [QS_W-1:0]            sq_sum_r;
  logic signed [MEAN_W-1:0]   mean_r;
  logic [ROOT_W-1:0]          sigma_r;
  logic [D_W-1:0]             pa_r, pb_r, d_r;
  logic [2*CNT_W-1:0]         nn_r;
  logic [DEN_W-1:0]           den_r;
  logic [DIST_W-1:0]          dist_r;
  logic [THR_W-1:0]           thr_r;

  logic [IDX_W-1:0]           idx, ld_idx;
  logic                       full;
  logic signed [2*SAMPLE_W-1:0] sq_full;
  logic [SUM_W-1:0]           abs_sum;
  logic [D_W-1:0]             pa_full, pb_full;
  logic [3*CNT_W-1:0]         den_full;
  logic [MQ_W:0]              mq_ext, mean_neg;
  logic signed [DIFF_W-1:0]   diff;
  logic [THR_W-1:0]           thr_full;
  logic                       drop_hit;

  logic              div_start, div_busy, div_done;
  logic [DIVD_W-1:0] div_dividend, div_quot;
  logic [DEN_W-1:0]  div_divisor, div_rem;
  logic              sqrt_busy, sqrt_done;
  logic [ROOT_W-1:0] root;

  assign idx     = idx_r[IDX_W-1:0];
  assign ld_idx  = load_cnt_r[IDX_W-1:0];
  assign full    = (load_cnt_r == CNT_W'(MAX_SAMPLES));
  assign sq_full = (2*SAMPLE_W)'(rd_data_r) * (2*SAMPLE_W)'(rd_data_r);
  assign abs_sum = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign pa_full = D_W'(n_r) * D_W'(sq_sum_r);
  assign pb_full = D_W'(abs_sum) * D_W'(abs_sum);
  assign den_full = (3*CNT_W)'(nn_r) * (3*CNT_W)'(n_r - 1'b1);
  assign mq_ext   = {1'b0, div_quot[MQ_W-1:0]};
  // floor for a negative sum: negate and step down when a remainder is left
  assign mean_neg = (~mq_ext + 1'b1) - (MQ_W+1)'(div_rem != '0);
  assign diff     = (DIFF_W'(rd_data_r) <<< MEAN_FRAC) - DIFF_W'(mean_r);
  assign thr_full = THR_W'(cm_r) * THR_W'(sigma_r);
  assign drop_hit = keep_r[idx] && (THR_W'({dist_r, 4'b0}) > thr_r);

  assign div_start    = cmd.mean_go | cmd.var_go;
  assign div_dividend = cmd.var_go ? {d_r, {VAR_FRAC{1'b0}}}
                                   : DIVD_W'({abs_sum, {MEAN_FRAC{1'b0}}});
  assign div_divisor  = cmd.var_go ? den_r : DEN_W'(n_r);

  isc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  isc_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.var_fin),
    .radicand (div_quot[V_W-1:0]),
    .busy     (sqrt_busy),
    .done     (sqrt_done),
    .root     (root)
  );

  // sample store
  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      mem[ld_idx] <= in_sample;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[idx];
    end
  end

  // control state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cm_r        <= CM_RESET;
      load_cnt_r  <= '0;
      keep_r      <= '0;
      ovf_r       <= 1'b0;
      idx_r       <= '0;
      n_r         <= '0;
      dropped_r   <= 1'b0;
      passes_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cm_r <= cfg_wr_data;
      end
      if (cmd.load) begin
        if (!full) begin
          keep_r[ld_idx] <= in_present && (in_sample != '0);
          load_cnt_r     <= load_cnt_r + 1'b1;
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.st_clr) begin
        idx_r <= '0;
        n_r   <= '0;
      end
      if (cmd.acc) begin
        if (keep_r[idx]) begin
          n_r <= n_r + 1'b1;
        end
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.sqrt_fin) begin
        passes_r <= passes_r + 1'b1;
      end
      if (cmd.cl_clr) begin
        idx_r     <= '0;
        dropped_r <= 1'b0;
      end
      if (cmd.cl_cmp) begin
        if (drop_hit) begin
          keep_r[idx] <= 1'b0;
          dropped_r   <= 1'b1;
        end
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.em_clr) begin
        idx_r <= '0;
      end
      if (cmd.em_load) begin
        idx_r       <= idx_r + 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.end_clr) begin
        load_cnt_r <= '0;
        keep_r     <= '0;
        ovf_r      <= 1'b0;
        passes_r   <= '0;
      end
    end
  end

  // arithmetic registers
  always_ff @(posedge clk) begin
    if (cmd.st_clr) begin
      sum_r    <= '0;
      sq_sum_r <= '0;
      mean_r   <= '0;
      sigma_r  <= '0;
    end
    if (cmd.sq) begin
      sq_r <= sq_full[SQ_W-1:0];
    end
    if (cmd.acc && keep_r[idx]) begin
      sum_r    <= sum_r + SUM_W'(rd_data_r);
      sq_sum_r <= sq_sum_r + QS_W'(sq_r);
    end
    if (cmd.mean_fin) begin
      mean_r <= sum_r[SUM_W-1] ? MEAN_W'(mean_neg) : MEAN_W'(mq_ext);
    end
    if (cmd.var_a) begin
      pa_r <= pa_full;
      pb_r <= pb_full;
      nn_r <= (2*CNT_W)'(n_r) * (2*CNT_W)'(n_r);
    end
    if (cmd.var_b) begin
      d_r   <= pa_r - pb_r;
      den_r <= den_full[DEN_W-1:0];
    end
    if (cmd.sqrt_fin) begin
      sigma_r <= root;
    end
    if (cmd.cl_clr) begin
      thr_r <= thr_full;
    end
    if (cmd.cl_mul) begin
      dist_r <= diff[DIFF_W-1] ? DIST_W'(-diff) : DIST_W'(diff);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.em_load) begin
      out_index       <= OUT_IDX_W'(idx);
      out_value       <= rd_data_r;
      out_kept        <= keep_r[idx];
      out_final_mean  <= mean_r;
      out_final_sigma <= sigma_r[ROOT_W-1] ? {SIGMA_W{1'b1}} : sigma_r[SIGMA_W-1:0];
      out_passes      <= passes_r;
      out_kept_count  <= n_r;
      out_stats_valid <= (n_r >= CNT_W'(2));
      out_overflowed  <= ovf_r;
      out_last_result <= (idx_r + 1'b1 == load_cnt_r);
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    st.idx_end   = (idx_r == load_cnt_r);
    st.n_zero    = (n_r == '0);
    st.n_lt2     = (n_r < CNT_W'(2));
    st.dropped   = dropped_r;
    st.div_busy  = div_busy;
    st.div_done  = div_done;
    st.sqrt_busy = sqrt_busy;
    st.sqrt_done = sqrt_done;
    st.out_free  = !out_valid_r || out_ready;
    st.cnt_zero  = (load_cnt_r == '0);
  end

endmodule

// ===== rtl/core/isc_ctrl.sv =====
// Sequencer for load, statistics, clip and emit phases.
// Depends on isc_pkg and the assertion macro header.
`include "iterative_sigma_clip_unit_assert.svh"
module isc_ctrl import isc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_last,
  input  isc_status_t st,
  output isc_cmd_t    cmd,
  output logic        in_ready
);

  isc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD:      if (in_valid && in_last) state_nxt = S_ST_CLR;
      S_ST_CLR:    state_nxt = S_ST_RD;
      S_ST_RD: begin
        if (!st.idx_end) state_nxt = S_ST_SQ;
        else if (st.n_zero) state_nxt = S_EM_CLR;
        else state_nxt = S_MEAN_GO;
      end
      S_ST_SQ:     state_nxt = S_ST_ACC;
      S_ST_ACC:    state_nxt = S_ST_RD;
      S_MEAN_GO:   state_nxt = S_MEAN_WAIT;
      S_MEAN_WAIT: if (st.div_done) state_nxt = st.n_lt2 ? S_EM_CLR : S_VAR_A;
      S_VAR_A:     state_nxt = S_VAR_B;
      S_VAR_B:     state_nxt = S_VAR_GO;
      S_VAR_GO:    state_nxt = S_VAR_WAIT;
      S_VAR_WAIT:  if (st.div_done) state_nxt = S_SQRT_WAIT;
      S_SQRT_WAIT: if (st.sqrt_done) state_nxt = S_CL_CLR;
      S_CL_CLR:    state_nxt = S_CL_RD;
      S_CL_RD: begin
        if (!st.idx_end) state_nxt = S_CL_MUL;
        else state_nxt = st.dropped ? S_ST_CLR : S_EM_CLR;
      end
      S_CL_MUL:    state_nxt = S_CL_CMP;
      S_CL_CMP:    state_nxt = S_CL_RD;
      S_EM_CLR:    state_nxt = S_EM_RD;
      S_EM_RD:     state_nxt = st.idx_end ? S_END : S_EM_OUT;
      S_EM_OUT:    if (st.out_free) state_nxt = S_EM_RD;
      S_END:       state_nxt = S_LOAD;
      default:     state_nxt = S_LOAD;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_ST_CLR:    cmd.st_clr = 1'b1;
      S_ST_RD:     cmd.rd = !st.idx_end;
      S_ST_SQ:     cmd.sq = 1'b1;
      S_ST_ACC:    cmd.acc = 1'b1;
      S_MEAN_GO:   cmd.mean_go = 1'b1;
      S_MEAN_WAIT: cmd.mean_fin = st.div_done;
      S_VAR_A:     cmd.var_a = 1'b1;
      S_VAR_B:     cmd.var_b = 1'b1;
      S_VAR_GO:    cmd.var_go = 1'b1;
      S_VAR_WAIT:  cmd.var_fin = st.div_done;
      S_SQRT_WAIT: cmd.sqrt_fin = st.sqrt_done;
      S_CL_CLR:    cmd.cl_clr = 1'b1;
      S_CL_RD:     cmd.rd = !st.idx_end;
      S_CL_MUL:    cmd.cl_mul = 1'b1;
      S_CL_CMP:    cmd.cl_cmp = 1'b1;
      S_EM_CLR:    cmd.em_clr = 1'b1;
      S_EM_RD:     cmd.rd = !st.idx_end;
      S_EM_OUT:    cmd.em_load = st.out_free;
      S_END:       cmd.end_clr = 1'b1;
      default:     cmd = '0;
    endcase
  end

  `ISC_ASSERT_IMP(a_div_start_idle, cmd.mean_go || cmd.var_go, !st.div_busy)
  `ISC_ASSERT_IMP(a_sqrt_start_idle, cmd.var_fin, !st.sqrt_busy)
  `ISC_ASSERT_IMP(a_load_units_idle, cmd.load, !st.div_busy && !st.sqrt_busy)
  `ISC_ASSERT_NXT(a_end_clears_count, state_r == S_END, st.cnt_zero)

endmodule

// ===== rtl/core/iterative_sigma_clip_unit.sv =====
// Iterative sigma clipping unit, top level.
// Input channel loads a series of samples; the item with in_last set closes
// the series and starts clipping. Each pass takes the mean and the sample
// sigma (n-1) of the kept samples and drops those further than
// clip_multiplier (Q4.4) times sigma from the mean, until a pass drops none.
// The result channel then carries one item per stored sample, in order,
// with the final statistics; out_last_result marks the last one.
// Loading: one item per cycle while the block is in its load phase.
// Each pass scans the sample store one sample at a time and runs the
// bit-serial divider twice (mean, variance) and the square root once.
// Clipping also stops once fewer than two samples are kept.
// Results leave through an output register: a stalled receiver holds the
// emit scan, and a new series can be loaded while the last result waits.
// Samples past 64 are dropped and reported through out_overflowed.
// Synchronous reset empties the series and sets clip_multiplier to 5.0.
// Depends on isc_pkg, isc_ctrl and isc_datapath.
module iterative_sigma_clip_unit import isc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [CM_W-1:0]            cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_present,
  input  logic                       in_last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [OUT_IDX_W-1:0]       out_index,
  output logic signed [SAMPLE_W-1:0] out_value,
  output logic                       out_kept,
  output logic signed [MEAN_W-1:0]   out_final_mean,
  output logic [SIGMA_W-1:0]         out_final_sigma,
  output logic [PASS_W-1:0]          out_passes,
  output logic [CNT_W-1:0]           out_kept_count,
  output logic                       out_stats_valid,
  output logic                       out_overflowed,
  output logic                       out_last_result
);

  isc_cmd_t    cmd;
  isc_status_t st;

  isc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_last),
    .st       (st),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  isc_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_sample       (in_sample),
    .in_present      (in_present),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_index       (out_index),
    .out_value       (out_value),
    .out_kept        (out_kept),
    .out_final_mean  (out_final_mean),
    .out_final_sigma (out_final_sigma),
    .out_passes      (out_passes),
    .out_kept_count  (out_kept_count),
    .out_stats_valid (out_stats_valid),
    .out_overflowed  (out_overflowed),
    .out_last_result (out_last_result)
  );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for iterative_sigma_clip_unit: directed and random sample series.
// The results are checked against a predictor of the clipping passes.
// Depends on isc_pkg and the RTL of the unit.
`timescale 1ns / 100ps

module tb_top;
  import isc_pkg::*;

  localparam int IDLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 420;

  typedef struct {
    logic [OUT_IDX_W-1:0]       index;
    logic signed [SAMPLE_W-1:0] value;
    logic                       kept;
    logic signed [MEAN_W-1:0]   mean;
    logic [SIGMA_W-1:0]         sigma;
    logic [PASS_W-1:0]          passes;
    logic [CNT_W-1:0]           kept_count;
    logic                       stats_valid;
    logic                       overflowed;
    logic                       last_result;
  } clip_result_t;

  typedef struct {
    int sample;
    bit present;
    bit last;
    bit typed;
    bit typed_kept;
  } series_row_t;

  logic clk, rst_n;
  logic cfg_wr_en;
  logic [CM_W-1:0] cfg_wr_data;
  logic in_valid, in_ready;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic in_present, in_last;
  logic out_valid, out_ready;
  logic [OUT_IDX_W-1:0] out_index;
  logic signed [SAMPLE_W-1:0] out_value;
  logic out_kept;
  logic signed [MEAN_W-1:0] out_final_mean;
  logic [SIGMA_W-1:0] out_final_sigma;
  logic [PASS_W-1:0] out_passes;
  logic [CNT_W-1:0] out_kept_count;
  logic out_stats_valid, out_overflowed, out_last_result;

  iterative_sigma_clip_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_sample(in_sample), .in_present(in_present), .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_index(out_index), .out_value(out_value), .out_kept(out_kept),
    .out_final_mean(out_final_mean), .out_final_sigma(out_final_sigma),
    .out_passes(out_passes), .out_kept_count(out_kept_count),
    .out_stats_valid(out_stats_valid), .out_overflowed(out_overflowed),
    .out_last_result(out_last_result)
  );

  // Predictor state
  logic signed [SAMPLE_W-1:0] series_store [MAX_SAMPLES];
  bit series_keep [MAX_SAMPLES];
  int series_len;
  bit series_ovf;
  longint unsigned clip_mult;

  clip_result_t pending_results[$];
  int mismatches, items_sent, results_seen, series_done, overflow_series;
  bit long_hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Mean and sample sigma of the kept set, both Q.8
  function automatic int kept_stats(output longint mean, output longint unsigned sig);
    longint s, num, q, x, ns;
    longint unsigned sq, abs_s, d, den, a, r, v, nu;
    int n;
    n = 0; s = 0; sq = 0; mean = 0; sig = 0;
    for (int i = 0; i < series_len; i++) begin
      if (series_keep[i]) begin
        x = series_store[i];
        s += x;
        sq += longint'(x * x);
        n++;
      end
    end
    if (n == 0) return 0;
    ns = n;
    num = s * 256;
    q = num / ns;
    if (num % ns != 0 && num < 0) q--;
    mean = q;
    if (n < 2) return n;
    nu = n;
    abs_s = (s < 0) ? -s : s;
    d = nu * sq - abs_s * abs_s;
    den = nu * nu * (nu - 1);
    a = d / den;
    r = d % den;
    v = (a << 16) + ((r << 16) / den);
    sig = int_sqrt(v);
    return n;
  endfunction

  // Load one item into the predicted series; on the last item clip and queue results
  task automatic absorb_sample(int sample, bit present, bit last);
    longint mean, diff;
    longint unsigned sig, distance;
    int n, passes;
    bit dropped;
    clip_result_t res;
    if (series_len < MAX_SAMPLES) begin
      series_store[series_len] = SAMPLE_W'(sample);
      series_keep[series_len] = present && (sample != 0);
      series_len++;
    end else begin
      series_ovf = 1;
    end
    if (!last) return;
    passes = 0;
    forever begin
      dropped = 0;
      n = kept_stats(mean, sig);
      if (n < 2) break;
      passes++;
      for (int i = 0; i < series_len; i++) begin
        if (series_keep[i]) begin
          diff = longint'(series_store[i]) * 256 - mean;
          distance = (diff < 0) ? -diff : diff;
          if (distance * 16 > clip_mult * sig) begin
            series_keep[i] = 0;
            dropped = 1;
          end
        end
      end
      if (!dropped) break;
    end
    n = kept_stats(mean, sig);
    for (int i = 0; i < series_len; i++) begin
      res.index = OUT_IDX_W'(i);
      res.value = series_store[i];
      res.kept = series_keep[i];
      res.mean = mean[31:0];
      res.sigma = (sig > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : sig[30:0];
      res.passes = PASS_W'(passes);
      res.kept_count = CNT_W'(n);
      res.stats_valid = (n >= 2);
      res.overflowed = series_ovf;
      res.last_result = (i + 1 == series_len);
      pending_results.push_back(res);
    end
    if (series_ovf) overflow_series++;
    series_done++;
    series_len = 0;
    series_ovf = 0;
    for (int i = 0; i < MAX_SAMPLES; i++) series_keep[i] = 0;
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    if (mismatches < 30)
      $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, results_seen);
    mismatches++;
  endtask

  // Result checker
  always @(posedge clk) begin
    clip_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, index", out_index, -1);
      end else begin
        e = pending_results.pop_front();
        if (out_index !== e.index) report_mismatch("index", out_index, e.index);
        if (out_value !== e.value) report_mismatch("value", out_value, e.value);
        if (out_kept !== e.kept) report_mismatch("kept", out_kept, e.kept);
        if (out_final_mean !== e.mean) report_mismatch("final_mean", out_final_mean, e.mean);
        if (out_final_sigma !== e.sigma)
          report_mismatch("final_sigma", out_final_sigma, e.sigma);
        if (out_passes !== e.passes) report_mismatch("passes", out_passes, e.passes);
        if (out_kept_count !== e.kept_count)
          report_mismatch("kept_count", out_kept_count, e.kept_count);
        if (out_stats_valid !== e.stats_valid)
          report_mismatch("stats_valid", out_stats_valid, e.stats_valid);
        if (out_overflowed !== e.overflowed)
          report_mismatch("overflowed", out_overflowed, e.overflowed);
        if (out_last_result !== e.last_result)
          report_mismatch("last_result", out_last_result, e.last_result);
      end
      results_seen++;
    end
  end

  // Receiver: random stalls, calm stretches, and one long hold on request
  initial begin
    int stall_left, calm_left;
    stall_left = 0;
    calm_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (1500) @(posedge clk);
        long_hold_req = 0;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (calm_left > 0) begin
        out_ready <= 1'b1;
        calm_left--;
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:2]:   stall_left = $urandom_range(10, 60);
          [3:6]:   calm_left = $urandom_range(20, 200);
          [7:30]:  stall_left = $urandom_range(0, 3);
          default: ;
        endcase
        out_ready <= (stall_left == 0);
      end
    end
  end

  // Watchdog on cycles with nothing accepted
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  // Offer one item, hold it until taken, then drop valid unless the next follows at once
  task automatic send_sample(int sample, bit present, bit last);
    int gap;
    in_valid <= 1'b1;
    in_sample <= SAMPLE_W'(sample);
    in_present <= present;
    in_last <= last;
    do @(posedge clk); while (!in_ready);
    absorb_sample(sample, present, last);
    items_sent++;
    case ($urandom_range(0, 19)) inside
      [0:13]:  gap = 0;
      [14:18]: gap = $urandom_range(1, 3);
      default: gap = $urandom_range(10, 40);
    endcase
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_multiplier(logic [CM_W-1:0] m);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    clip_mult = m;
  endtask

  task automatic send_random_series();
    int len, base, spread, v;
    case ($urandom_range(0, 99)) inside
      [0:4]:   len = 1;
      [5:84]:  len = $urandom_range(2, 12);
      [85:94]: len = $urandom_range(13, 40);
      default: len = $urandom_range(64, 70);
    endcase
    base = $signed($urandom_range(0, 2097151)) - 1048576;
    spread = 1 << $urandom_range(0, 14);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 19)) inside
        [0:1]:   v = $signed({$urandom} << 8) >>> 8;
        [2:3]:   v = base + ($signed($urandom_range(0, 400)) - 200) * spread;
        4:       v = 0;
        default: v = base + $signed($urandom_range(0, 2 * spread)) - spread;
      endcase
      if (v > 8388607) v = 8388607;
      if (v < -8388608) v = -8388608;
      send_sample(v, $urandom_range(0, 99) < 92, i == len - 1);
    end
  endtask

  series_row_t directed_rows[] = '{
    '{8388607, 1, 1, 1, 1},
    '{-8388608, 1, 1, 1, 1},
    '{0, 1, 1, 1, 0},
    '{77, 0, 1, 1, 0},
    '{10, 1, 0, 0, 0}, '{12, 1, 0, 0, 0}, '{0, 1, 0, 0, 0}, '{11, 1, 0, 0, 0},
    '{33, 0, 0, 0, 0}, '{9, 1, 0, 0, 0}, '{10, 1, 0, 0, 0}, '{5000, 1, 1, 0, 0},
    '{8388607, 1, 0, 0, 0}, '{-8388608, 1, 1, 0, 0},
    '{100, 1, 0, 0, 0}, '{100, 1, 0, 0, 0}, '{100, 1, 1, 0, 0},
    '{-1, 1, 0, 0, 0}, '{1, 1, 0, 0, 0}, '{-5592405, 1, 0, 0, 0},
    '{5592405, 1, 1, 0, 0}
  };

  initial begin
    logic [CM_W-1:0] phase_mult [5];
    clip_result_t lit;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_sample = '0;
    in_present = 1'b0;
    in_last = 1'b0;
    mismatches = 0; items_sent = 0; results_seen = 0;
    series_done = 0; overflow_series = 0;
    long_hold_req = 0;
    series_len = 0;
    series_ovf = 0;
    clip_mult = CM_RESET;
    for (int i = 0; i < MAX_SAMPLES; i++) series_keep[i] = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows; single-sample series carry a literal expectation
    foreach (directed_rows[r]) begin
      send_sample(directed_rows[r].sample, directed_rows[r].present, directed_rows[r].last);
      if (directed_rows[r].typed) begin
        pending_results.pop_back();
        lit.index = 0;
        lit.value = SAMPLE_W'(directed_rows[r].sample);
        lit.kept = directed_rows[r].typed_kept;
        lit.mean = directed_rows[r].typed_kept ? directed_rows[r].sample * 256 : 0;
        lit.sigma = 0;
        lit.passes = 0;
        lit.kept_count = CNT_W'(directed_rows[r].typed_kept);
        lit.stats_valid = 0;
        lit.overflowed = 0;
        lit.last_result = 1;
        pending_results.push_back(lit);
      end
    end
    drain_results();

    phase_mult = '{8'd0, 8'd255, 8'd8, 8'd40, 8'($urandom_range(1, 254))};
    for (int p = 0; p < 5; p++) begin
      write_multiplier(phase_mult[p]);
      if (p == 1) begin
        // Long receiver hold while full series keep coming
        long_hold_req = 1;
        for (int k = 0; k < 64; k++) send_sample($urandom_range(1, 500), 1, 0);
        send_sample(90000, 1, 1);
        send_random_series();
      end
      while (items_sent < (p + 1) * RANDOM_ITEMS / 5 + directed_rows.size())
        send_random_series();
      drain_results();
    end

    repeat (50) @(posedge clk);
    $display("covered %0d items in %0d series (%0d past capacity), %0d results checked",
             items_sent, series_done, overflow_series, results_seen);
    $display("multipliers 5.0, 0, 15.9375, 0.5, 2.5 and a random one; %0d mismatches",
             mismatches);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/isc_pkg.sv
rtl/core/isc_div.sv
rtl/core/isc_sqrt.sv
rtl/core/isc_datapath.sv
rtl/core/isc_ctrl.sv
rtl/core/iterative_sigma_clip_unit.sv
tb/tb_top.sv
